// ===== design/dqcd_pkg.sv =====
// dqcd_pkg: shared widths, constants, types and small tables of the daily quota block
// no dependencies; imported by every module of the block

package dqcd_pkg;

	localparam int NSTG       = 10;
	localparam int LIMIT_W    = 16;
	localparam int OFS_W      = 18;
	localparam int SECS_W     = 36;
	localparam int CNT_W      = 16;
	localparam int YEAR_W     = 13;
	localparam int MONTH_W    = 4;
	localparam int DAYM_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] REG_DAILY_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAY_OFFSET  = 1'd1;

	localparam logic CMD_RESERVE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [LIMIT_W-1:0]      LIMIT_RST = 16'd1500;
	localparam logic signed [OFS_W-1:0] OFS_RST   = -18'sd18000;

	// day number: floor(t / 86400) = floor(floor(t / 128) / 675)
	localparam int T_W          = SECS_W + 2;
	localparam int DAY_W        = 21;
	localparam int U_W          = 30;
	localparam int DAY_SHIFT    = 7;
	localparam int DAY_ODD      = 675;
	localparam int DAY_BIAS     = 2;
	localparam int DAY_RECIP_SH = 40;
	localparam int DAY_RECIP_W  = 31;
	localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
		DAY_RECIP_W'(((64'd1 << DAY_RECIP_SH) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

	// civil date conversion
	localparam int Z_W            = 21;
	localparam int EPOCH_SHIFT    = 719468;
	localparam int DAYS_PER_ERA   = 146097;
	localparam int ERA_MAX        = 10;
	localparam int ERA_W          = 4;
	localparam int YEARS_PER_ERA  = 400;
	localparam int YEARS_PER_CENT = 100;
	localparam int YB_W           = 12;
	localparam int DOE_W          = 18;
	localparam int DAYS_PER_4Y    = 1460;
	localparam int DAYS_PER_CENT  = 36524;
	localparam int DAYS_PER_YEAR  = 365;
	localparam int YOE_W          = 9;
	localparam int DOY_W          = 9;
	localparam int MP_W           = 4;
	localparam int MPX_W          = 11;
	localparam int MP_DIV         = 153;

	localparam int DIV_SH   = 32;
	localparam int R1460_W  = 22;
	localparam int R365_W   = 24;
	localparam int MP_SH    = 24;
	localparam int R153_W   = 17;
	localparam logic [R1460_W-1:0] RECIP_1460 =
		R1460_W'(((64'd1 << DIV_SH) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));
	localparam logic [R365_W-1:0] RECIP_365 =
		R365_W'(((64'd1 << DIV_SH) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));
	localparam logic [R153_W-1:0] RECIP_153 =
		R153_W'(((64'd1 << MP_SH) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));

	typedef logic [NSTG-1:0] stage_vec_t;

	typedef struct packed {
		logic             granted;
		logic [CNT_W-1:0] used;
		logic             rolled;
	} qres_t;

	function automatic logic [ERA_W-1:0] era_count(input logic [Z_W-1:0] z);
		logic [ERA_W-1:0] n;
		n = '0;
		for (int k = 1; k <= ERA_MAX; k++) begin
			if (z >= Z_W'(k * DAYS_PER_ERA))
				n = n + ERA_W'(1);
		end
		return n;
	endfunction

	function automatic logic [2:0] cent_count(input logic [DOE_W-1:0] doe);
		logic [2:0] n;
		n = '0;
		for (int k = 1; k <= 4; k++) begin
			if (doe >= DOE_W'(k * DAYS_PER_CENT))
				n = n + 3'd1;
		end
		return n;
	endfunction

	function automatic logic [1:0] yoe_cent(input logic [YOE_W-1:0] yoe);
		logic [1:0] n;
		n = '0;
		for (int k = 1; k <= 3; k++) begin
			if (yoe >= YOE_W'(k * YEARS_PER_CENT))
				n = n + 2'd1;
		end
		return n;
	endfunction

	// (153 * mp + 2) / 5
	function automatic logic [DOY_W-1:0] mp_ofs(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/dqcd_pipe_ctrl.sv =====
// dqcd_pipe_ctrl: valid bits and per-stage load enables of the ten-stage pipeline
// depends on dqcd_pkg

module dqcd_pipe_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	output dqcd_pkg::stage_vec_t   take
);
	import dqcd_pkg::*;

	stage_vec_t vld_q;
	stage_vec_t rdy;
	stage_vec_t prev;

	always_comb begin
		rdy[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
		for (int k = NSTG - 2; k >= 0; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign prev      = {vld_q[NSTG-2:0], in_valid};
	assign take      = rdy & prev;
	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (rdy & prev) | (~rdy & vld_q);
		end
	end

endmodule

// ===== design/dqcd_day.sv =====
// dqcd_day: input register and the floor division of offset time into a day number
// depends on dqcd_pkg; stages s1 to s3

module dqcd_day (
	input  logic                                clk,
	input  dqcd_pkg::stage_vec_t                take,
	input  logic                                cmd,
	input  logic [dqcd_pkg::SECS_W-1:0]         unix_seconds,
	input  logic signed [dqcd_pkg::OFS_W-1:0]   offset,
	output logic                                cmd_s3,
	output logic signed [dqcd_pkg::DAY_W-1:0]   day_s3
);
	import dqcd_pkg::*;

	logic                          cmd_s1;
	logic [SECS_W-1:0]             secs_s1;
	logic                          cmd_s2;
	logic [U_W-1:0]                u_s2;
	logic signed [T_W-1:0]         t;
	logic signed [T_W-1:0]         t_sh;
	logic [U_W-1:0]                u;
	logic [U_W+DAY_RECIP_W-1:0]    prod;
	logic [DAY_W-1:0]              q;

	// biased so the quotient never goes negative
	always_comb begin
		t    = signed'({2'b00, secs_s1}) + T_W'(offset);
		t_sh = t >>> DAY_SHIFT;
		u    = U_W'(t_sh + T_W'(DAY_BIAS * DAY_ODD));
	end

	always_comb begin
		prod = (U_W+DAY_RECIP_W)'(u_s2) * (U_W+DAY_RECIP_W)'(DAY_RECIP);
		q    = prod[DAY_RECIP_SH +: DAY_W];
	end

	always_ff @(posedge clk) begin
		if (take[0]) begin
			cmd_s1  <= cmd;
			secs_s1 <= unix_seconds;
		end
		if (take[1]) begin
			cmd_s2 <= cmd_s1;
			u_s2   <= u;
		end
		if (take[2]) begin
			cmd_s3 <= cmd_s2;
			day_s3 <= signed'(q - DAY_W'(DAY_BIAS));
		end
	end

endmodule

// ===== design/dqcd_quota.sv =====
// dqcd_quota: stored day and used count, grant and release decision
// depends on dqcd_pkg; reads stage s3, loads stage s4

module dqcd_quota (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dqcd_pkg::stage_vec_t                take,
	input  logic                                cmd_s3,
	input  logic signed [dqcd_pkg::DAY_W-1:0]   day_s3,
	input  logic [dqcd_pkg::LIMIT_W-1:0]        limit,
	output dqcd_pkg::qres_t                     qres_s4
);
	import dqcd_pkg::*;

	logic [DAY_W-1:0] cur_day_q;
	logic             known_q;
	logic [CNT_W-1:0] used_q;
	logic             new_day;
	logic [CNT_W-1:0] base;
	qres_t            res;

	always_comb begin
		new_day     = !known_q || (cur_day_q != DAY_W'(day_s3));
		base        = new_day ? '0 : used_q;
		res.rolled  = known_q && (cur_day_q != DAY_W'(day_s3));
		res.granted = 1'b0;
		res.used    = base;
		case (cmd_s3)
			CMD_RESERVE: begin
				if (base < limit) begin
					res.granted = 1'b1;
					res.used    = base + CNT_W'(1);
				end
			end
			CMD_RELEASE: begin
				if (base != '0)
					res.used = base - CNT_W'(1);
			end
			default: res.used = base;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q <= '0;
			known_q   <= 1'b0;
			used_q    <= '0;
		end else if (take[3]) begin
			cur_day_q <= DAY_W'(day_s3);
			known_q   <= 1'b1;
			used_q    <= res.used;
		end
	end

	always_ff @(posedge clk) begin
		if (take[3])
			qres_s4 <= res;
	end

endmodule

// ===== design/dqcd_civil.sv =====
// dqcd_civil: day number to Gregorian year, month and day, plus result register
// depends on dqcd_pkg; stages s4 to s10

module dqcd_civil (
	input  logic                                clk,
	input  dqcd_pkg::stage_vec_t                take,
	input  logic signed [dqcd_pkg::DAY_W-1:0]   day_s3,
	input  dqcd_pkg::qres_t                     qres_s4,
	output dqcd_pkg::qres_t                     qres_s10,
	output logic [dqcd_pkg::YEAR_W-1:0]         year_s10,
	output logic [dqcd_pkg::MONTH_W-1:0]        month_s10,
	output logic [dqcd_pkg::DAYM_W-1:0]         mday_s10
);
	import dqcd_pkg::*;

	logic [Z_W-1:0]             z_s4;
	logic [DOE_W-1:0]           doe_s5, doe_s6, doe_s7;
	logic [YB_W-1:0]            yb_s5, yb_s6, yb_s7;
	logic [DOE_W-1:0]           num_s6;
	logic [YOE_W-1:0]           yoe_s7;
	logic [DOY_W-1:0]           doy_s8, doy_s9;
	logic [YEAR_W-1:0]          y_s8, y_s9;
	logic [MP_W-1:0]            mp_s9;
	qres_t                      qres_s5, qres_s6, qres_s7, qres_s8, qres_s9;

	logic [ERA_W-1:0]           era;
	logic [DOE_W-1:0]           doe;
	logic [YB_W-1:0]            yb;
	logic [DOE_W+R1460_W-1:0]   p1460;
	logic [DOE_W-1:0]           num;
	logic [DOE_W+R365_W-1:0]    p365;
	logic [YOE_W-1:0]           yoe;
	logic [DOE_W-1:0]           yday;
	logic [DOY_W-1:0]           doy;
	logic [YEAR_W-1:0]          y;
	logic [MPX_W-1:0]           mpx;
	logic [MPX_W+R153_W-1:0]    p153;
	logic [MP_W-1:0]            mp;
	logic [MONTH_W-1:0]         month;
	logic [DAYM_W-1:0]          mday;
	logic [YEAR_W-1:0]          year;

	// era and day of era
	always_comb begin
		era = era_count(z_s4);
		doe = DOE_W'(z_s4 - Z_W'(era * DAYS_PER_ERA));
		yb  = YB_W'(era * YEARS_PER_ERA);
	end

	always_comb begin
		p1460 = (DOE_W+R1460_W)'(doe_s5) * (DOE_W+R1460_W)'(RECIP_1460);
		num   = doe_s5 - DOE_W'(p1460[DIV_SH +: 8]) + DOE_W'(cent_count(doe_s5))
			- DOE_W'(doe_s5 >= DOE_W'(DAYS_PER_ERA - 1));
	end

	always_comb begin
		p365 = (DOE_W+R365_W)'(num_s6) * (DOE_W+R365_W)'(RECIP_365);
		yoe  = p365[DIV_SH +: YOE_W];
	end

	// day of year, march based
	always_comb begin
		yday = DOE_W'(yoe_s7) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe_s7 >> 2)
			- DOE_W'(yoe_cent(yoe_s7));
		doy  = DOY_W'(doe_s7 - yday);
		y    = YEAR_W'(yb_s7) + YEAR_W'(yoe_s7);
	end

	always_comb begin
		mpx  = {doy_s8, 2'b00} + MPX_W'(doy_s8) + MPX_W'(2);
		p153 = (MPX_W+R153_W)'(mpx) * (MPX_W+R153_W)'(RECIP_153);
		mp   = p153[MP_SH +: MP_W];
	end

	always_comb begin
		mday  = DAYM_W'(doy_s9 - mp_ofs(mp_s9) + DOY_W'(1));
		month = (mp_s9 < MP_W'(10)) ? mp_s9 + MONTH_W'(3) : mp_s9 - MONTH_W'(9);
		year  = y_s9 + YEAR_W'(month <= MONTH_W'(2));
	end

	always_ff @(posedge clk) begin
		if (take[3])
			z_s4 <= Z_W'(day_s3) + Z_W'(EPOCH_SHIFT);
		if (take[4]) begin
			doe_s5  <= doe;
			yb_s5   <= yb;
			qres_s5 <= qres_s4;
		end
		if (take[5]) begin
			num_s6  <= num;
			doe_s6  <= doe_s5;
			yb_s6   <= yb_s5;
			qres_s6 <= qres_s5;
		end
		if (take[6]) begin
			yoe_s7  <= yoe;
			doe_s7  <= doe_s6;
			yb_s7   <= yb_s6;
			qres_s7 <= qres_s6;
		end
		if (take[7]) begin
			doy_s8  <= doy;
			y_s8    <= y;
			qres_s8 <= qres_s7;
		end
		if (take[8]) begin
			mp_s9   <= mp;
			doy_s9  <= doy_s8;
			y_s9    <= y_s8;
			qres_s9 <= qres_s8;
		end
		if (take[9]) begin
			qres_s10  <= qres_s9;
			year_s10  <= year;
			month_s10 <= month;
			mday_s10  <= mday;
		end
	end

endmodule

// ===== design/daily_quota_with_civil_date.sv =====
// daily_quota_with_civil_date: per-day reservation quota with Gregorian date of the offset day
// pipeline: ten register stages, s1 to s10, lie between the request taken at the input and the result
// throughput: one request per cycle unless stalled; depth set by the reciprocal multiplies of the date math
// a held result only stalls the input once every stage behind it is occupied
// reset: asynchronous, empties the pipeline, limit 1500, offset -18000 s, no day known, count 0
// depends on dqcd_pkg, dqcd_pipe_ctrl, dqcd_day, dqcd_quota, dqcd_civil

module daily_quota_with_civil_date (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write_en,
	input  logic [dqcd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dqcd_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  cmd,
	input  logic [dqcd_pkg::SECS_W-1:0]           unix_seconds,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  granted,
	output logic [dqcd_pkg::CNT_W-1:0]            used_count,
	output logic                                  day_rolled,
	output logic [dqcd_pkg::YEAR_W-1:0]           civil_year,
	output logic [dqcd_pkg::MONTH_W-1:0]          civil_month,
	output logic [dqcd_pkg::DAYM_W-1:0]           civil_day
);
	import dqcd_pkg::*;

	logic [LIMIT_W-1:0]      limit_q;
	logic signed [OFS_W-1:0] offset_q;
	stage_vec_t              take;
	logic                    cmd_s3;
	logic signed [DAY_W-1:0] day_s3;
	qres_t                   qres_s4;
	qres_t                   qres_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RST;
			offset_q <= OFS_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_DAILY_LIMIT: limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_DAY_OFFSET:  offset_q <= signed'(cfg_data[OFS_W-1:0]);
				default: ;
			endcase
		end
	end

	dqcd_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.take      (take)
	);

	dqcd_day u_day (
		.clk          (clk),
		.take         (take),
		.cmd          (cmd),
		.unix_seconds (unix_seconds),
		.offset       (offset_q),
		.cmd_s3       (cmd_s3),
		.day_s3       (day_s3)
	);

	dqcd_quota u_quota (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.cmd_s3  (cmd_s3),
		.day_s3  (day_s3),
		.limit   (limit_q),
		.qres_s4 (qres_s4)
	);

	dqcd_civil u_civil (
		.clk       (clk),
		.take      (take),
		.day_s3    (day_s3),
		.qres_s4   (qres_s4),
		.qres_s10  (qres_s10),
		.year_s10  (civil_year),
		.month_s10 (civil_month),
		.mday_s10  (civil_day)
	);

	assign granted    = qres_s10.granted;
	assign used_count = qres_s10.used;
	assign day_rolled = qres_s10.rolled;

	a_stall_only_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output side is free");

	a_grant_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> used_count != '0)
		else $error("granted reserve with zero count");

	a_roll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && day_rolled |-> used_count <= CNT_W'(1))
		else $error("day rollover did not clear the count");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> civil_month >= MONTH_W'(1) && civil_month <= MONTH_W'(12)
			&& civil_day >= DAYM_W'(1) && civil_day <= DAYM_W'(31))
		else $error("civil date out of range");

endmodule
